FILE: hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Scale pitch quantizer package
// Shared widths, codes, handshake structs and the exp2 root table.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Fraction bits of every log2 value.
    localparam int LFB = 24;
    // Full log2 of a 30-bit integer: 5 integer bits and LFB fraction bits.
    localparam int LW  = 5 + LFB;
    // Note log width: log2 of a ratio in [1, 4).
    localparam int NW  = LFB + 1;
    // Field widths.
    localparam int PW  = 30;
    localparam int RW  = 18;
    localparam int OW  = 10;
    localparam int SW  = 3;
    localparam int CIW = 2;

    // Request codes.
    localparam logic REQ_QUANT = 1'b0;
    localparam logic REQ_LOAD  = 1'b1;

    // Status codes.
    localparam logic [SW-1:0] ST_OK     = 3'd0;
    localparam logic [SW-1:0] ST_ZERO   = 3'd1;
    localparam logic [SW-1:0] ST_EMPTY  = 3'd2;
    localparam logic [SW-1:0] ST_SAT    = 3'd3;
    localparam logic [SW-1:0] ST_STORED = 3'd4;

    // Configuration register indexes.
    localparam logic [CIW-1:0] CFG_BASE   = 2'd0;
    localparam logic [CIW-1:0] CFG_REPEAT = 2'd1;
    localparam logic [CIW-1:0] CFG_COUNT  = 2'd2;

    // log2 of 2^16, the Q2.16 ratio scale.
    localparam logic [LW-1:0] LOG_16 = LW'(16 << LFB);

    // Request to and response from the log2 unit.
    typedef struct packed {
        logic          start;
        logic [PW-1:0] x;
    } t_log_req;

    typedef struct packed {
        logic          done;
        logic [LW-1:0] value;
    } t_log_rsp;

    // Root table for exp2: entry k is 2^(2^-k) in Q2.30.
    typedef logic [LFB:0][31:0] t_root_tab;

    function automatic logic [63:0] f_isqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        r = '0;
        x = v;
        for (int i = 0; i < 32; i++) begin
            b = 64'd1 << (62 - 2 * i);
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    function automatic t_root_tab f_roots();
        t_root_tab   tab;
        logic [63:0] s;
        tab[0] = 32'h8000_0000;
        for (int k = 1; k <= LFB; k++) begin
            s      = f_isqrt({32'd0, tab[k-1]} << 30);
            tab[k] = s[31:0];
        end
        return tab;
    endfunction

    localparam t_root_tab ROOTS = f_roots();

endpackage

FILE: hdl/spq_in_if.sv
// ----------------------------------------------------------------------------
// Scale pitch quantizer input channel
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface spq_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [29:0] pitch;
    logic [4:0]  note_slot;
    logic [17:0] note_ratio;

    modport source (output valid, req_type, pitch, note_slot, note_ratio, input ready);
    modport sink   (input valid, req_type, pitch, note_slot, note_ratio, output ready);
endinterface

FILE: hdl/spq_out_if.sv
// ----------------------------------------------------------------------------
// Scale pitch quantizer output channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface spq_out_if;
    logic              valid;
    logic              ready;
    logic [29:0]       closest_pitch;
    logic signed [9:0] octave_number;
    logic [2:0]        status;

    modport source (output valid, closest_pitch, octave_number, status, input ready);
    modport sink   (input valid, closest_pitch, octave_number, status, output ready);
endinterface

FILE: hdl/spq_cfg_if.sv
// ----------------------------------------------------------------------------
// Scale pitch quantizer configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface spq_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [29:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/spq_log2.sv
// ----------------------------------------------------------------------------
// Scale pitch quantizer log2 unit
// Iterative log2 of a nonzero 30-bit integer: one normalizing shift or one
// mantissa squaring per cycle.
// ----------------------------------------------------------------------------
module spq_log2 import spq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_log_req i_req,
    output t_log_rsp o_rsp
);

    localparam int KW = $clog2(LFB + 1);

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_NORM = 3'b010,
        L_SQR  = 3'b100
    } t_lstate;

    t_lstate         r_state;
    logic            r_done;
    logic [30:0]     r_y;
    logic [4:0]      r_m;
    logic [LFB-1:0]  r_frac;
    logic [KW-1:0]   r_k;
    logic [61:0]     w_sq;
    logic [31:0]     w_q;

    // Square of the Q1.30 mantissa, brought back to Q1.30 (or Q2.30 on overflow).
    assign w_sq = r_y * r_y;
    assign w_q  = w_sq[61:30];

    // Sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                L_IDLE: begin
                    if (i_req.start) r_state <= L_NORM;
                end
                L_NORM: begin
                    if (r_y[30]) r_state <= L_SQR;
                end
                L_SQR: begin
                    if (r_k == KW'(LFB - 1)) begin
                        r_state <= L_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    // Mantissa, exponent and fraction bits.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            L_IDLE: begin
                r_y <= {i_req.x, 1'b0};
                r_m <= 5'd29;
            end
            L_NORM: begin
                r_k    <= '0;
                r_frac <= '0;
                if (!r_y[30]) begin
                    r_y <= {r_y[29:0], 1'b0};
                    r_m <= r_m - 5'd1;
                end
            end
            L_SQR: begin
                r_frac <= {r_frac[LFB-2:0], w_q[31]};
                r_y    <= w_q[31] ? w_q[31:1] : w_q[30:0];
                r_k    <= r_k + KW'(1);
            end
            default: r_y <= r_y;
        endcase
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = {r_m, r_frac};

endmodule

FILE: hdl/scale_pitch_quantizer_unit.sv
// ----------------------------------------------------------------------------
// Scale pitch quantizer
// Snaps a pitch to the nearest note of a repeating scale held in a note RAM.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one request item: a note load (req_type 1) stores log2 of
//   note_ratio into slot note_slot; a query (req_type 0) quantizes pitch.
//   o_out returns exactly one result item per request item.
//   i_cfg writes base_note (0), repeat_factor (1) and note_count (2); it is
//   always ready and must only be used while the block is idle.
// Operation:
//   One item at a time. A load runs one log2. A query runs three log2 passes
//   (normalizing shifts plus 24 squarings each), a 29-bit restoring division,
//   a linear scan of the note RAM (plus a read of the last note when wrapping
//   below the first note), and 24 exp2 multiply steps unless the result
//   saturates. Zero pitch and empty scale go straight to the output.
// Reset:
//   Control and configuration registers return to their defaults; the note RAM
//   is not cleared and entries are undefined until loaded.
// Stall:
//   A result waits in the output register; the next item is accepted while it
//   waits, and its own result is held back until the register is free.
// ----------------------------------------------------------------------------
module scale_pitch_quantizer_unit import spq_pkg::*; #(
    parameter int MAX_NOTES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spq_in_if.sink     i_in,
    spq_out_if.source  o_out,
    spq_cfg_if.sink    i_cfg
);

    localparam int AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int CW = $clog2(MAX_NOTES + 1);
    localparam int KW = $clog2(LFB + 1);
    localparam int TW = LFB + 10;
    localparam int HW = NW + 2;
    localparam logic signed [TW-1:0] T_SAT = TW'(64'd30 << LFB);
    localparam logic [PW-1:0] PITCH_MAX = '1;

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_STORE = 16'h0002,
        S_LRF   = 16'h0004,
        S_LP    = 16'h0008,
        S_LB    = 16'h0010,
        S_DIV   = 16'h0020,
        S_POST  = 16'h0040,
        S_RD    = 16'h0080,
        S_CK    = 16'h0100,
        S_RDL   = 16'h0200,
        S_CKL   = 16'h0400,
        S_PICK  = 16'h0800,
        S_EXPI  = 16'h1000,
        S_EXP   = 16'h2000,
        S_FIN   = 16'h4000,
        S_OUT   = 16'h8000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [PW-1:0] r_base;
    logic [RW-1:0] r_rf;
    logic [5:0]    r_ncount;

    // Note RAM.
    logic [NW-1:0] mem [MAX_NOTES];
    logic [AW-1:0] r_raddr;
    logic [NW-1:0] r_rdata;

    // Log unit.
    t_log_req r_lreq;
    t_log_rsp w_lrsp;

    // Working registers.
    logic                 r_slot_ok;
    logic [AW-1:0]        r_slot;
    logic [PW-1:0]        r_pitch;
    logic [CW-1:0]        r_cnt;
    logic [NW-1:0]        r_lr;
    logic [LW-1:0]        r_lp;
    logic                 r_neg;
    logic [LW-1:0]        r_dq;
    logic [NW-1:0]        r_rem;
    logic [4:0]           r_dcnt;
    logic signed [LW+1:0] r_n;
    logic [NW-1:0]        r_off;
    logic [CW-1:0]        r_up;
    logic [NW-1:0]        r_e0;
    logic [NW-1:0]        r_prev;
    logic signed [HW-1:0] r_lo;
    logic signed [HW-1:0] r_hi;
    logic                 r_uplow;
    logic                 r_upcnt;
    logic signed [HW-1:0] r_chosen;
    logic signed [1:0]    r_adj;
    logic signed [9:0]    r_ip;
    logic [LFB-1:0]       r_f;
    logic [30:0]          r_m;
    logic [KW-1:0]        r_k;

    // Pending and output result.
    logic [PW-1:0]        r_p_pitch;
    logic signed [OW-1:0] r_p_oct;
    logic [SW-1:0]        r_p_status;
    logic                 r_ovalid;
    logic [PW-1:0]        r_o_pitch;
    logic signed [OW-1:0] r_o_oct;
    logic [SW-1:0]        r_o_status;

    // Combinational helpers.
    logic                 w_accept;
    logic                 w_out_free;
    logic [PW-1:0]        w_base_eff;
    logic [RW-1:0]        w_rf_eff;
    logic [RW-1:0]        w_ratio_eff;
    logic [CW-1:0]        w_cnt;
    logic [LW-1:0]        w_lr_full;
    logic signed [LW:0]   w_la;
    logic signed [LW:0]   w_la_abs;
    logic [NW:0]          w_rem_sh;
    logic                 w_ge;
    logic                 w_rnz;
    logic [NW-1:0]        w_e0v;
    logic signed [HW:0]   w_dlo;
    logic signed [HW:0]   w_dhi;
    logic signed [TW-1:0] w_t;
    logic signed [LW+2:0] w_oct;
    logic [61:0]          w_prod;
    logic [5:0]           w_s;
    logic [40:0]          w_rnd;
    logic [40:0]          w_v;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_ovalid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // Guards for out-of-range register settings and note ratios.
    assign w_base_eff  = (r_base == '0) ? PW'(1) : r_base;
    assign w_rf_eff    = (r_rf > 18'd65536) ? r_rf : 18'd65537;
    assign w_ratio_eff = (i_in.note_ratio < 18'd65536) ? 18'd65536 : i_in.note_ratio;
    assign w_cnt       = ({2'b00, r_ncount} > 8'(MAX_NOTES)) ? CW'(MAX_NOTES)
                                                              : CW'(r_ncount);

    // Period log, pitch log difference and division step.
    assign w_lr_full = w_lrsp.value - LOG_16;
    assign w_la      = $signed({1'b0, r_lp}) - $signed({1'b0, w_lrsp.value});
    assign w_la_abs  = (w_la < 0) ? -w_la : w_la;
    assign w_rem_sh  = {r_rem, r_dq[LW-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_lr});
    assign w_rnz     = (r_rem != '0);

    // Neighbor selection and target log.
    assign w_e0v = (r_up == '0) ? r_rdata : r_e0;
    assign w_dlo = $signed({3'b000, r_off}) - $signed({r_lo[HW-1], r_lo});
    assign w_dhi = $signed({r_hi[HW-1], r_hi}) - $signed({3'b000, r_off});
    assign w_t   = $signed({{(TW-LW){1'b0}}, r_lp}) - $signed({{(TW-NW){1'b0}}, r_off})
                 + $signed({{(TW-HW){r_chosen[HW-1]}}, r_chosen});
    assign w_oct = $signed({r_n[LW+1], r_n}) + $signed({{(LW+1){r_adj[1]}}, r_adj});

    // exp2 multiply step and final rounding shift.
    assign w_prod = r_m * ROOTS[r_k][30:0];
    assign w_s    = 6'(10'sd30 - r_ip);
    assign w_rnd  = {10'd0, r_m} + (41'd1 << (w_s - 6'd1));
    assign w_v    = w_rnd >> w_s;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= PW'(28835840);
            r_rf     <= RW'(131072);
            r_ncount <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_BASE:   r_base   <= i_cfg.data;
                CFG_REPEAT: r_rf     <= i_cfg.data[RW-1:0];
                CFG_COUNT:  r_ncount <= i_cfg.data[5:0];
                default:    r_base   <= r_base;
            endcase
        end
    end

    // Note RAM write port: log of a loaded ratio.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_STORE) && w_lrsp.done && r_slot_ok) begin
            mem[r_slot] <= w_lr_full[NW-1:0];
        end
    end

    // Note RAM read port, registered.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_RD) || (r_state == S_RDL)) begin
            r_rdata <= mem[r_raddr];
        end
    end

    // Control: state, log requests and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lreq   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_lreq.start <= 1'b0;
            if (o_out.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        priority if (i_in.req_type == REQ_LOAD) begin
                            r_lreq.start <= 1'b1;
                            r_lreq.x     <= PW'(w_ratio_eff);
                            r_state      <= S_STORE;
                        end else if (i_in.pitch == '0) begin
                            r_state <= S_OUT;
                        end else if (r_ncount == '0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_lreq.start <= 1'b1;
                            r_lreq.x     <= PW'(w_rf_eff);
                            r_state      <= S_LRF;
                        end
                    end
                end
                S_STORE: if (w_lrsp.done) r_state <= S_OUT;
                S_LRF: begin
                    if (w_lrsp.done) begin
                        r_lreq.start <= 1'b1;
                        r_lreq.x     <= r_pitch;
                        r_state      <= S_LP;
                    end
                end
                S_LP: begin
                    if (w_lrsp.done) begin
                        r_lreq.start <= 1'b1;
                        r_lreq.x     <= w_base_eff;
                        r_state      <= S_LB;
                    end
                end
                S_LB:   if (w_lrsp.done) r_state <= S_DIV;
                S_DIV:  if (r_dcnt == 5'(LW - 1)) r_state <= S_POST;
                S_POST: r_state <= S_RD;
                S_RD:   r_state <= S_CK;
                S_CK: begin
                    priority if (r_rdata > r_off) begin
                        r_state <= (r_up == '0) ? S_RDL : S_PICK;
                    end else if (r_up == r_cnt - CW'(1)) begin
                        r_state <= S_PICK;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RDL: r_state <= S_CKL;
                S_CKL: r_state <= S_PICK;
                S_PICK: r_state <= S_EXPI;
                S_EXPI: r_state <= (w_t >= T_SAT) ? S_OUT : S_EXP;
                S_EXP:  if (r_k == KW'(LFB)) r_state <= S_FIN;
                S_FIN:  r_state <= S_OUT;
                S_OUT: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_slot_ok  <= ({3'b000, i_in.note_slot} < 8'(MAX_NOTES));
                r_slot     <= AW'({3'b000, i_in.note_slot});
                r_pitch    <= i_in.pitch;
                r_cnt      <= w_cnt;
                r_p_pitch  <= '0;
                r_p_oct    <= '0;
                r_p_status <= (i_in.pitch == '0) ? ST_ZERO : ST_EMPTY;
            end
            S_STORE: r_p_status <= ST_STORED;
            S_LRF: begin
                r_lr <= (w_lr_full[NW-1:0] == '0) ? NW'(1) : w_lr_full[NW-1:0];
            end
            S_LP: r_lp <= w_lrsp.value;
            S_LB: begin
                r_neg  <= (w_la < 0);
                r_dq   <= w_la_abs[LW-1:0];
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            // One quotient bit per cycle.
            S_DIV: begin
                r_rem  <= w_ge ? NW'(w_rem_sh - {1'b0, r_lr}) : w_rem_sh[NW-1:0];
                r_dq   <= {r_dq[LW-2:0], w_ge};
                r_dcnt <= r_dcnt + 5'd1;
            end
            // Floor octave and in-period offset from quotient and remainder.
            S_POST: begin
                if (r_neg) begin
                    r_n   <= -$signed({2'b00, r_dq} + (LW+2)'(w_rnz));
                    r_off <= w_rnz ? (r_lr - r_rem) : '0;
                end else begin
                    r_n   <= $signed({2'b00, r_dq});
                    r_off <= r_rem;
                end
                r_up    <= '0;
                r_raddr <= '0;
            end
            S_RD: r_up <= r_up;
            // Linear search for the first note above the offset.
            S_CK: begin
                if (r_up == '0) r_e0 <= r_rdata;
                r_prev <= r_rdata;
                priority if (r_rdata > r_off) begin
                    r_hi    <= $signed({2'b00, r_rdata});
                    r_lo    <= $signed({2'b00, r_prev});
                    r_uplow <= (r_up == '0);
                    r_upcnt <= 1'b0;
                    r_raddr <= AW'(r_cnt - CW'(1));
                end else if (r_up == r_cnt - CW'(1)) begin
                    r_lo    <= $signed({2'b00, r_rdata});
                    r_hi    <= $signed({2'b00, w_e0v}) + $signed({2'b00, r_lr});
                    r_uplow <= 1'b0;
                    r_upcnt <= 1'b1;
                end else begin
                    r_up    <= r_up + CW'(1);
                    r_raddr <= AW'(r_up + CW'(1));
                end
            end
            S_RDL: r_up <= r_up;
            // Wrap below the first note: last note one period down.
            S_CKL: r_lo <= $signed({2'b00, r_rdata}) - $signed({2'b00, r_lr});
            // Nearer neighbor in log, ties going up.
            S_PICK: begin
                if (w_dlo < w_dhi) begin
                    r_chosen <= r_lo;
                    r_adj    <= r_uplow ? -2'sd1 : 2'sd0;
                end else begin
                    r_chosen <= r_hi;
                    r_adj    <= r_upcnt ? 2'sd1 : 2'sd0;
                end
            end
            S_EXPI: begin
                if (w_oct > (LW+3)'(511)) begin
                    r_p_oct <= 10'sd511;
                end else if (w_oct < -(LW+3)'(512)) begin
                    r_p_oct <= -10'sd512;
                end else begin
                    r_p_oct <= w_oct[OW-1:0];
                end
                r_p_pitch  <= PITCH_MAX;
                r_p_status <= ST_SAT;
                r_ip       <= w_t[TW-1:LFB];
                r_f        <= w_t[LFB-1:0];
                r_m        <= 31'h4000_0000;
                r_k        <= KW'(1);
            end
            // One root multiply per fraction bit, most significant first.
            S_EXP: begin
                if (r_f[LFB-1]) r_m <= w_prod[60:30];
                r_f <= {r_f[LFB-2:0], 1'b0};
                r_k <= r_k + KW'(1);
            end
            // Scale by the integer part with round half up.
            S_FIN: begin
                priority if (r_ip < -10'sd10) begin
                    r_p_pitch  <= '0;
                    r_p_status <= ST_OK;
                end else if (w_v > {11'd0, PITCH_MAX}) begin
                    r_p_pitch  <= PITCH_MAX;
                    r_p_status <= ST_SAT;
                end else begin
                    r_p_pitch  <= w_v[PW-1:0];
                    r_p_status <= ST_OK;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_o_pitch  <= r_p_pitch;
                    r_o_oct    <= r_p_oct;
                    r_o_status <= r_p_status;
                end
            end
            default: r_up <= r_up;
        endcase
    end

    spq_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_lreq),
        .o_rsp   (w_lrsp)
    );

    assign o_out.valid         = r_ovalid;
    assign o_out.closest_pitch = r_o_pitch;
    assign o_out.octave_number = r_o_oct;
    assign o_out.status        = r_o_status;

endmodule

FILE: sim/scale_pitch_quantizer_unit_test.sv
// ----------------------------------------------------------------------------
// Scale pitch quantizer testbench
// Drives note loads, queries and register writes, predicts every result item
// with a fixed-point model of the quantizer and checks the results in order.
// ----------------------------------------------------------------------------
module scale_pitch_quantizer_unit_test;
    import spq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int           NOTE_SLOTS = 32;
    localparam int           HOLD_LIMIT = 6000000;
    localparam longint       LOG_ONE    = longint'(1) << LFB;
    localparam logic [29:0]  PITCH_TOP  = 30'h3FFF_FFFF;

    typedef struct packed {
        logic [29:0]       pitch;
        logic signed [9:0] octave;
        logic [2:0]        status;
    } t_quant;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind      kind;
        logic           req;
        logic [29:0]    pitch;
        logic [4:0]     slot;
        logic [17:0]    ratio;
        logic [CIW-1:0] reg_idx;
        logic [29:0]    reg_data;
        bit             typed;
        logic [2:0]     typed_status;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    spq_in_if  in_ch();
    spq_out_if out_ch();
    spq_cfg_if cfg_ch();

    scale_pitch_quantizer_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Predictor state: registers, note log table and exp2 roots.
    longint unsigned root_q30[LFB+1];
    longint unsigned note_log[NOTE_SLOTS];
    bit              slot_loaded[NOTE_SLOTS];
    longint unsigned base_reg;
    longint unsigned period_reg;
    longint unsigned count_reg;

    t_quant pending_q[$];
    int     send_idle_pct;
    int     recv_idle_pct;
    int     mismatches;
    longint cycle_count;

    // Bitwise integer square root.
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // log2 of x > 0 with LFB fraction bits, by repeated squaring.
    function automatic longint unsigned log2_fix(input longint unsigned x);
        int              msb;
        longint unsigned y;
        longint unsigned frac;
        msb  = 63;
        frac = 0;
        while (msb > 0 && x[msb] == 1'b0) msb--;
        y = (msb >= 30) ? (x >> (msb - 30)) : (x << (30 - msb));
        for (int i = 0; i < LFB; i++) begin
            y    = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (64'd2 << 30)) begin
                y    = y >> 1;
                frac = frac | 1;
            end
        end
        return (longint'(msb) << LFB) | frac;
    endfunction

    // Rounded 2^(t / 2^LFB); flags saturation above the pitch maximum.
    function automatic longint unsigned exp2_fix(input longint t, output bit sat);
        longint          ip;
        longint          sh;
        longint unsigned f;
        longint unsigned m;
        longint unsigned v;
        sat = 0;
        if (t >= 30 * LOG_ONE) begin
            sat = 1;
            return PITCH_TOP;
        end
        if (t >= 0) ip = t >>> LFB;
        else ip = -((-t + LOG_ONE - 1) >>> LFB);
        f = t - ip * LOG_ONE;
        m = 64'd1 << 30;
        for (int k = 1; k <= LFB; k++)
            if (f[LFB-k]) m = (m * root_q30[k]) >> 30;
        sh = 30 - ip;
        if (sh > 40) return 0;
        v = (m + (64'd1 << (sh - 1))) >> sh;
        if (v > PITCH_TOP) begin
            sat = 1;
            return PITCH_TOP;
        end
        return v;
    endfunction

    // Expected result of one accepted request item; updates the note table.
    function automatic t_quant quantize(input logic req, input logic [29:0] pitch,
                                        input logic [4:0] slot, input logic [17:0] ratio);
        t_quant          q;
        longint unsigned cnt;
        longint unsigned base;
        longint unsigned rf;
        longint unsigned r;
        longint          lr, la, n, off, lo, hi, chosen, oct, t;
        int              up;
        int              adj;
        bit              sat;
        q = '0;
        if (req == REQ_LOAD) begin
            r = (ratio < 18'd65536) ? 64'd65536 : 64'(ratio);
            note_log[slot] = log2_fix(r) - (64'd16 << LFB);
            q.status = ST_STORED;
            return q;
        end
        if (pitch == 0) begin
            q.status = ST_ZERO;
            return q;
        end
        cnt = (count_reg > NOTE_SLOTS) ? NOTE_SLOTS : count_reg;
        if (cnt == 0) begin
            q.status = ST_EMPTY;
            return q;
        end
        base = (base_reg != 0) ? base_reg : 1;
        rf   = (period_reg > 65536) ? period_reg : 65537;
        lr   = longint'(log2_fix(rf)) - (longint'(16) << LFB);
        if (lr <= 0) lr = 1;
        la = longint'(log2_fix(pitch)) - longint'(log2_fix(base));
        if (la >= 0) n = la / lr;
        else n = -((-la + lr - 1) / lr);
        off = la - n * lr;
        // Linear search for the first note above the in-period offset.
        up = int'(cnt);
        for (int i = 0; i < int'(cnt); i++)
            if (longint'(note_log[i]) > off) begin
                up = i;
                break;
            end
        lo = (up == 0) ? longint'(note_log[cnt-1]) - lr : longint'(note_log[up-1]);
        hi = (up == int'(cnt)) ? longint'(note_log[0]) + lr : longint'(note_log[up]);
        // Nearer neighbor wins, a tie goes upward.
        if (off - lo < hi - off) begin
            chosen = lo;
            adj    = (up == 0) ? -1 : 0;
        end else begin
            chosen = hi;
            adj    = (up == int'(cnt)) ? 1 : 0;
        end
        t = longint'(log2_fix(base)) + n * lr + chosen;
        q.pitch = 30'(exp2_fix(t, sat));
        oct = n + adj;
        if (oct > 511) oct = 511;
        if (oct < -512) oct = -512;
        q.octave = 10'(oct);
        q.status = sat ? ST_SAT : ST_OK;
        return q;
    endfunction

    // Clock and cycle limit.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > HOLD_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver stalls at random.
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each result item with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: pitch %0d octave %0d status %0d",
                             out_ch.closest_pitch, out_ch.octave_number, out_ch.status);
            end else begin
                automatic t_quant e = pending_q.pop_front();
                if (out_ch.closest_pitch !== e.pitch || out_ch.octave_number !== e.octave
                        || out_ch.status !== e.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected pitch %0d octave %0d status %0d, %s %0d %0d %0d",
                                 e.pitch, e.octave, e.status, "got",
                                 out_ch.closest_pitch, out_ch.octave_number, out_ch.status);
                end
            end
        end
    end

    // Send one request item; the expectation is queued on acceptance.
    task automatic send_request(input logic req, input logic [29:0] pitch,
                                input logic [4:0] slot, input logic [17:0] ratio,
                                input bit typed, input logic [2:0] typed_status);
        t_quant q;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.req_type   <= req;
        in_ch.pitch      <= pitch;
        in_ch.note_slot  <= slot;
        in_ch.note_ratio <= ratio;
        do @(posedge i_clk); while (!in_ch.ready);
        q = quantize(req, pitch, slot, ratio);
        if (req == REQ_LOAD) slot_loaded[slot] = 1;
        if (typed) q = '{pitch: '0, octave: '0, status: typed_status};
        pending_q.push_back(q);
        @(negedge i_clk);
    endtask

    // Register write, only once every result has come back.
    task automatic write_reg(input logic [CIW-1:0] idx, input logic [29:0] data);
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_q.size() != 0) @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_BASE:   base_reg   = data;
            CFG_REPEAT: period_reg = data[17:0];
            CFG_COUNT:  count_reg  = data[5:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // One random phase: registers, a well-formed scale, then queries.
    task automatic run_scale_phase(input int n_queries);
        int             cnt;
        logic [17:0]    rf;
        logic [29:0]    base;
        logic [29:0]    p;
        int unsigned    ratios[$];
        bit             all_loaded;
        case ($urandom_range(5))
            0:       base = 30'd1;
            1:       base = PITCH_TOP;
            default: base = 30'($urandom_range(30'h3FFF_FFFF, 1)) >> $urandom_range(29);
        endcase
        if (base == 0) base = 1;
        case ($urandom_range(5))
            0:       rf = 18'd69632;
            1:       rf = 18'd262143;
            default: rf = 18'($urandom_range(262143, 69632));
        endcase
        cnt = ($urandom_range(3) == 0) ? $urandom_range(32, 1) : $urandom_range(12, 1);
        write_reg(CFG_BASE, base);
        write_reg(CFG_REPEAT, 30'(rf));
        ratios = {};
        for (int i = 0; i < cnt; i++) ratios.push_back($urandom_range(rf - 1, 65536));
        if ($urandom_range(9) != 0) ratios.sort();
        for (int i = 0; i < cnt; i++)
            send_request(REQ_LOAD, 30'($urandom), 5'(i), 18'(ratios[i]), 0, '0);
        all_loaded = 1;
        foreach (slot_loaded[i]) if (!slot_loaded[i]) all_loaded = 0;
        if (all_loaded && $urandom_range(5) == 0)
            write_reg(CFG_COUNT, 30'($urandom_range(63, 33)));
        else
            write_reg(CFG_COUNT, 30'(cnt));
        for (int i = 0; i < n_queries; i++) begin
            case ($urandom_range(19))
                0:       p = '0;
                1:       p = 30'($urandom);
                2: begin
                    // Reload a slot that is already in use, as noise.
                    send_request(REQ_LOAD, 30'($urandom), 5'($urandom_range(cnt - 1)),
                                 18'($urandom), 0, '0);
                    continue;
                end
                default: p = 30'($urandom) >> $urandom_range(29);
            endcase
            send_request(REQ_QUANT, p, 5'($urandom), 18'($urandom), 0, '0);
        end
    endtask

    // Directed rows: zero-pitch and empty-scale queries, a twelve-tone scale, extremes.
    t_row rows[$];

    task automatic add_item(input logic req, input logic [29:0] p, input logic [4:0] s,
                            input logic [17:0] r, input bit typed, input logic [2:0] st);
        rows.push_back('{ROW_ITEM, req, p, s, r, '0, '0, typed, st});
    endtask

    task automatic add_reg(input logic [CIW-1:0] idx, input logic [29:0] data);
        rows.push_back('{ROW_REG, REQ_QUANT, '0, '0, '0, idx, data, 0, '0});
    endtask

    initial begin
        int unsigned tet[12];
        tet = '{0, 69433, 73562, 77936, 82570, 87480, 92682, 98193,
                104032, 110218, 116772, 123715};
        // Predictor reset state.
        root_q30[0] = 64'd2 << 30;
        for (int k = 1; k <= LFB; k++) root_q30[k] = int_sqrt(root_q30[k-1] << 30);
        foreach (note_log[i]) begin
            note_log[i]    = 0;
            slot_loaded[i] = 0;
        end
        base_reg      = 28835840;
        period_reg    = 131072;
        count_reg     = 0;
        mismatches    = 0;
        cycle_count   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;

        in_ch.valid      = 1'b0;
        in_ch.req_type   = REQ_QUANT;
        in_ch.pitch      = '0;
        in_ch.note_slot  = '0;
        in_ch.note_ratio = '0;
        out_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_BASE;
        cfg_ch.data      = '0;
        i_rst_n          = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        add_item(REQ_QUANT, '0, '0, '0, 1, ST_ZERO);
        add_item(REQ_QUANT, PITCH_TOP, '0, '0, 1, ST_EMPTY);
        add_item(REQ_QUANT, 30'd1, '0, '0, 1, ST_EMPTY);
        // A zero ratio in slot 0 is raised to unity.
        for (int i = 0; i < 12; i++) add_item(REQ_LOAD, '0, 5'(i), 18'(tet[i]), 1, ST_STORED);
        add_item(REQ_LOAD, PITCH_TOP, 5'd31, 18'h3FFFF, 1, ST_STORED);
        add_reg(CFG_COUNT, 30'd12);
        add_item(REQ_QUANT, 30'd28835840, '0, '0, 0, '0);
        add_item(REQ_QUANT, 30'd29000000, '0, '0, 0, '0);
        add_item(REQ_QUANT, 30'd27000000, '0, '0, 0, '0);
        add_item(REQ_QUANT, 30'd1, '0, '0, 0, '0);
        add_item(REQ_QUANT, PITCH_TOP, '0, '0, 0, '0);
        add_reg(CFG_BASE, PITCH_TOP);
        add_item(REQ_QUANT, PITCH_TOP, '0, '0, 0, '0);
        add_item(REQ_QUANT, 30'd1, '0, '0, 0, '0);
        // Out-of-range register values: zero base and a unity period.
        add_reg(CFG_BASE, '0);
        add_reg(CFG_REPEAT, 30'd65536);
        add_item(REQ_QUANT, PITCH_TOP, '0, '0, 0, '0);
        add_item(REQ_QUANT, 30'd1, '0, '0, 0, '0);
        add_reg(CFG_REPEAT, '0);
        add_item(REQ_QUANT, 30'd12345, '0, '0, 0, '0);

        @(negedge i_clk);
        foreach (rows[i]) begin
            if (rows[i].kind == ROW_REG)
                write_reg(rows[i].reg_idx, rows[i].reg_data);
            else
                send_request(rows[i].req, rows[i].pitch, rows[i].slot, rows[i].ratio,
                             rows[i].typed, rows[i].typed_status);
        end

        // Random part under three idling patterns.
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 17 : (mode == 1) ? 49 : 0;
            recv_idle_pct = (mode == 0) ? 49 : (mode == 1) ? 17 : 0;
            for (int ph = 0; ph < 6; ph++) run_scale_phase(60);
        end

        in_ch.valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
